// File: src/atms_pkg.sv
// ----------------------------------------------------------------------------
// atms_pkg: shared constants, types and tables for accel_tilt_mean_std
// Widths, CORDIC arctangent table and the data carried between the CORDIC cells.
// ----------------------------------------------------------------------------
`default_nettype none
package atms_pkg;

  localparam int COUNT_BITS   = 20;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);

  localparam int ACC_W     = 16;
  localparam int XY_W      = 34;
  localparam int Z_W       = 24;
  localparam int SUM_W     = COUNT_BITS + 16;
  localparam int SQ_W      = COUNT_BITS + 30;
  localparam int DIV_NUM_W = SQ_W + 32;
  localparam int ISQ_W     = 64;
  localparam int ROOT_W    = ISQ_W / 2;

  localparam int RES_RAW_W = 16 + 15 + COUNT_BITS + 16 + 15 + 15 + 14;
  localparam int OUT_W     = ((RES_RAW_W + 7) / 8) * 8;

  localparam logic signed [Z_W-1:0] PI_Q20    = Z_W'(3294199);
  localparam logic signed [Z_W-1:0] ROLL_CAP  = Z_W'(25736);
  localparam logic signed [Z_W-1:0] PITCH_CAP = Z_W'(12868);

  typedef struct packed {
    logic                   valid;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cor_t;

  function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
    logic signed [Z_W-1:0] r;
    r = '0;
    priority if (i == STEP_W'(0)) r = Z_W'(823550);
    else if (i == STEP_W'(1)) r = Z_W'(486170);
    else if (i == STEP_W'(2)) r = Z_W'(256879);
    else if (i == STEP_W'(3)) r = Z_W'(130396);
    else if (i == STEP_W'(4)) r = Z_W'(65451);
    else if (i == STEP_W'(5)) r = Z_W'(32757);
    else if (i == STEP_W'(6)) r = Z_W'(16383);
    else if (32'(i) <= 32'd20) r = Z_W'(1) <<< (5'd20 - 5'(i));
    else r = '0;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/atms_cordic_cell.sv
// ----------------------------------------------------------------------------
// atms_cordic_cell: one CORDIC vectoring micro-rotation
// Registered stage; hands its vector and angle to the next cell every cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module atms_cordic_cell (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [atms_pkg::STEP_W-1:0] step_i,
  input  wire atms_pkg::cor_t              cell_i,
  output atms_pkg::cor_t                   cell_o
);

  logic                             valid_q;
  logic signed [atms_pkg::XY_W-1:0] x_q, y_q, x_d, y_d, dx, dy;
  logic signed [atms_pkg::Z_W-1:0]  z_q, z_d, at;

  always_comb begin
    dx = cell_i.y >>> step_i;
    dy = cell_i.x >>> step_i;
    at = atms_pkg::atan_entry(step_i);
    if (!cell_i.y[atms_pkg::XY_W-1]) begin
      x_d = cell_i.x + dx;
      y_d = cell_i.y - dy;
      z_d = cell_i.z + at;
    end else begin
      x_d = cell_i.x - dx;
      y_d = cell_i.y + dy;
      z_d = cell_i.z - at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign cell_o = '{valid: valid_q, x: x_q, y: y_q, z: z_q};

endmodule
`default_nettype wire

// File: src/atms_isqrt.sv
// ----------------------------------------------------------------------------
// atms_isqrt: bit-serial integer square root
// Floor root of a 64-bit radicand, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module atms_isqrt (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [atms_pkg::ISQ_W-1:0]  rad_i,
  output logic                             busy_o,
  output logic [atms_pkg::ROOT_W-1:0]      root_o
);

  localparam int REM_W = atms_pkg::ROOT_W + 3;
  localparam int CNT_W = $clog2(atms_pkg::ROOT_W + 1);

  logic                          busy_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [atms_pkg::ISQ_W-1:0]    rad_q;
  logic [REM_W-1:0]              rem_q, rem_sh, trial, rem_d;
  logic [atms_pkg::ROOT_W-1:0]   root_q, root_d;

  always_comb begin
    rem_sh = {rem_q[REM_W-3:0], rad_q[atms_pkg::ISQ_W-1 -: 2]};
    trial  = REM_W'({root_q, 2'b01});
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_q[atms_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_q[atms_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(atms_pkg::ROOT_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[atms_pkg::ISQ_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

// File: src/atms_div.sv
// ----------------------------------------------------------------------------
// atms_div: bit-serial restoring divider
// Quotient of a wide numerator by the sample count, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module atms_div (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [atms_pkg::DIV_NUM_W-1:0]  num_i,
  input  wire logic [atms_pkg::COUNT_BITS-1:0] den_i,
  output logic                                 busy_o,
  output logic [atms_pkg::DIV_NUM_W-1:0]       quo_o
);

  localparam int CB    = atms_pkg::COUNT_BITS;
  localparam int NW    = atms_pkg::DIV_NUM_W;
  localparam int CNT_W = $clog2(NW + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NW-1:0]    num_q;
  logic [CB-1:0]    den_q, rem_q, rem_d;
  logic [CB:0]      rem_sh;
  logic             qbit;

  always_comb begin
    rem_sh = {rem_q, num_q[NW-1]};
    qbit   = rem_sh >= {1'b0, den_q};
    rem_d  = qbit ? CB'(rem_sh - {1'b0, den_q}) : rem_sh[CB-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NW-2:0], qbit};
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = num_q;

endmodule
`default_nettype wire

// File: src/accel_tilt_mean_std.sv
// ----------------------------------------------------------------------------
// accel_tilt_mean_std: tilt angles with running mean and standard deviation
// Each sample runs through two CORDIC passes, the serial divider (four quotients
// of DIV_NUM_W bits) and the root unit (three 32-bit roots) before its result is valid.
// One sample is processed at a time; the next sample is taken while a result waits.
// Asynchronous active-low reset clears sums, count, sequencer and output valid.
// ----------------------------------------------------------------------------
`default_nettype none
module accel_tilt_mean_std (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [47:0]  s_axis_tdata_i,  // accel_x, accel_y, accel_z
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // roll_angle, pitch_angle, samples_counted, roll_mean, pitch_mean,
  // roll_spread, pitch_spread
  output logic [atms_pkg::OUT_W-1:0] m_axis_tdata_o,
  output logic              m_axis_tuser_o   // count_full
);

  localparam int CB     = atms_pkg::COUNT_BITS;
  localparam int OUT_W  = atms_pkg::OUT_W;
  localparam int Z_W    = atms_pkg::Z_W;
  localparam int XY_W   = atms_pkg::XY_W;
  localparam int SUM_W  = atms_pkg::SUM_W;
  localparam int SQ_W   = atms_pkg::SQ_W;
  localparam int RW     = atms_pkg::ROOT_W;
  localparam int NW     = atms_pkg::DIV_NUM_W;

  localparam logic [1:0] DIV_MR = 2'd0;
  localparam logic [1:0] DIV_MP = 2'd1;
  localparam logic [1:0] DIV_ER = 2'd2;
  localparam logic [1:0] DIV_EP = 2'd3;

  typedef enum logic [16:0] {
    ST_IDLE  = 17'h00001,
    ST_ROLL  = 17'h00002,
    ST_WROLL = 17'h00004,
    ST_WMAG  = 17'h00008,
    ST_PITCH = 17'h00010,
    ST_WPIT  = 17'h00020,
    ST_SQ    = 17'h00040,
    ST_UPD   = 17'h00080,
    ST_DIV   = 17'h00100,
    ST_DWAIT = 17'h00200,
    ST_MSQ   = 17'h00400,
    ST_VAR   = 17'h00800,
    ST_SR    = 17'h01000,
    ST_SRW   = 17'h02000,
    ST_SP    = 17'h04000,
    ST_SPW   = 17'h08000,
    ST_OUT   = 17'h10000
  } st_e;

  st_e state_q, state_d;

  logic signed [15:0] ax_q, ay_q, az_q;
  logic signed [15:0] roll_q;
  logic signed [14:0] pitch_q;
  logic [29:0]        rsq_q, psq_q;
  logic               full_q;
  logic signed [SUM_W-1:0] roll_tot_q, pitch_tot_q;
  logic [SQ_W-1:0]    rsqt_q, psqt_q;
  logic [CB-1:0]      tally_q;
  logic [1:0]         div_idx_q;
  logic [RW-1:0]      mag_q, root_r_q, root_p_q;
  logic [30:0]        m_r_q, m_p_q;
  logic [61:0]        e_r_q, e_p_q, mr2_q, mp2_q, v_r_q, v_p_q;
  logic               out_valid_q, out_full_q;
  logic [OUT_W-1:0]   out_data_q;

  atms_pkg::cor_t cor_in;
  atms_pkg::cor_t chain [atms_pkg::CORDIC_STEPS+1];
  atms_pkg::cor_t chain_out;

  logic                     isq_start, isq_busy, div_start, div_busy;
  logic [atms_pkg::ISQ_W-1:0] isq_rad;
  logic [RW-1:0]            isq_root;
  logic [NW-1:0]            div_num, div_quo;

  logic                     in_fire, out_fire;
  logic signed [31:0]       pyy, pzz;
  logic [32:0]              sumsq;
  logic [SUM_W-1:0]         a_r, a_p;
  logic signed [Z_W-1:0]    roll_z, pitch_z;
  logic signed [15:0]       roll_new, pitch_new;
  logic [31:0]              mr_t, mp_t;
  logic [15:0]              mr_u, mp_u;
  logic [32:0]              sr_t, sp_t;
  logic [16:0]              sr_u, sp_u;
  logic signed [15:0]       roll_mean;
  logic signed [14:0]       pitch_mean;
  logic [14:0]              roll_spread;
  logic [13:0]              pitch_spread;

  function automatic logic signed [15:0] to_q13(input logic signed [Z_W-1:0] z,
                                                input logic signed [Z_W-1:0] cap);
    logic signed [Z_W-1:0] a;
    a = (z + Z_W'(64)) >>> 7;
    if (a > cap) a = cap;
    if (a < -cap) a = -cap;
    return 16'(a);
  endfunction

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = (state_q == ST_IDLE);

  // CORDIC feed
  always_comb begin
    cor_in = '0;
    if (state_q == ST_ROLL) begin
      cor_in.valid = 1'b1;
      if (az_q < 0) begin
        cor_in.x = (-XY_W'(az_q)) <<< 14;
        cor_in.y = (-XY_W'(ay_q)) <<< 14;
      end else begin
        cor_in.x = XY_W'(az_q) <<< 14;
        cor_in.y = XY_W'(ay_q) <<< 14;
      end
    end else if (state_q == ST_PITCH) begin
      cor_in.valid = 1'b1;
      cor_in.x = XY_W'(mag_q);
      cor_in.y = (-XY_W'(ax_q)) <<< 14;
    end
  end

  assign chain[0] = cor_in;

  for (genvar g = 0; g < atms_pkg::CORDIC_STEPS; g++) begin : g_cell
    atms_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (atms_pkg::STEP_W'(g)),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end
  assign chain_out = chain[atms_pkg::CORDIC_STEPS];

  // shared root unit
  always_comb begin
    pyy   = 32'(ay_q) * 32'(ay_q);
    pzz   = 32'(az_q) * 32'(az_q);
    sumsq = {1'b0, pyy} + {1'b0, pzz};
    isq_start = (state_q == ST_ROLL) || (state_q == ST_SR) || (state_q == ST_SP);
    isq_rad   = '0;
    if (state_q == ST_ROLL) isq_rad = atms_pkg::ISQ_W'({sumsq, 28'b0});
    else if (state_q == ST_SR) isq_rad = atms_pkg::ISQ_W'(v_r_q);
    else if (state_q == ST_SP) isq_rad = atms_pkg::ISQ_W'(v_p_q);
  end

  atms_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (isq_start),
    .rad_i   (isq_rad),
    .busy_o  (isq_busy),
    .root_o  (isq_root)
  );

  // shared divider
  always_comb begin
    a_r = roll_tot_q[SUM_W-1] ? SUM_W'(-roll_tot_q) : SUM_W'(roll_tot_q);
    a_p = pitch_tot_q[SUM_W-1] ? SUM_W'(-pitch_tot_q) : SUM_W'(pitch_tot_q);
    div_start = (state_q == ST_DIV);
    unique case (div_idx_q)
      DIV_MR:  div_num = NW'({a_r, 16'b0});
      DIV_MP:  div_num = NW'({a_p, 16'b0});
      DIV_ER:  div_num = NW'({rsqt_q, 32'b0});
      default: div_num = NW'({psqt_q, 32'b0});
    endcase
  end

  atms_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (tally_q),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  // angles
  always_comb begin
    roll_z = '0;
    if (!(ay_q == 16'sd0 && az_q == 16'sd0)) begin
      roll_z = chain_out.z;
      if (az_q < 0) roll_z = roll_z + ((ay_q >= 0) ? atms_pkg::PI_Q20 : -atms_pkg::PI_Q20);
    end
    pitch_z = (mag_q == '0 && ax_q == 16'sd0) ? '0 : chain_out.z;
    roll_new  = to_q13(roll_z, atms_pkg::ROLL_CAP);
    pitch_new = to_q13(pitch_z, atms_pkg::PITCH_CAP);
  end

  // result fields
  always_comb begin
    mr_t = 32'(m_r_q) + 32'd32768;
    mp_t = 32'(m_p_q) + 32'd32768;
    mr_u = mr_t[31:16];
    mp_u = mp_t[31:16];
    if (32'(mr_u) > 32'(atms_pkg::ROLL_CAP)) mr_u = 16'(atms_pkg::ROLL_CAP);
    if (32'(mp_u) > 32'(atms_pkg::PITCH_CAP)) mp_u = 16'(atms_pkg::PITCH_CAP);
    roll_mean  = roll_tot_q[SUM_W-1] ? -$signed(mr_u) : $signed(mr_u);
    pitch_mean = pitch_tot_q[SUM_W-1] ? 15'(-$signed(mp_u)) : 15'($signed(mp_u));
    sr_t = 33'(root_r_q) + 33'd32768;
    sp_t = 33'(root_p_q) + 33'd32768;
    sr_u = sr_t[32:16];
    sp_u = sp_t[32:16];
    if (32'(sr_u) > 32'(atms_pkg::ROLL_CAP)) sr_u = 17'(atms_pkg::ROLL_CAP);
    if (32'(sp_u) > 32'(atms_pkg::PITCH_CAP)) sp_u = 17'(atms_pkg::PITCH_CAP);
    roll_spread  = sr_u[14:0];
    pitch_spread = sp_u[13:0];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (s_axis_tvalid_i) state_d = ST_ROLL;
      ST_ROLL:  state_d = ST_WROLL;
      ST_WROLL: if (chain_out.valid) state_d = ST_WMAG;
      ST_WMAG:  if (!isq_busy) state_d = ST_PITCH;
      ST_PITCH: state_d = ST_WPIT;
      ST_WPIT:  if (chain_out.valid) state_d = ST_SQ;
      ST_SQ:    state_d = ST_UPD;
      ST_UPD:   state_d = ST_DIV;
      ST_DIV:   state_d = ST_DWAIT;
      ST_DWAIT: if (!div_busy) state_d = (div_idx_q == DIV_EP) ? ST_MSQ : ST_DIV;
      ST_MSQ:   state_d = ST_VAR;
      ST_VAR:   state_d = ST_SR;
      ST_SR:    state_d = ST_SRW;
      ST_SRW:   if (!isq_busy) state_d = ST_SP;
      ST_SP:    state_d = ST_SPW;
      ST_SPW:   if (!isq_busy) state_d = ST_OUT;
      ST_OUT:   if (out_fire) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_idx_q   <= DIV_MR;
      roll_tot_q  <= '0;
      pitch_tot_q <= '0;
      rsqt_q      <= '0;
      psqt_q      <= '0;
      tally_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DWAIT && !div_busy) div_idx_q <= div_idx_q + 2'd1;
      if (state_q == ST_UPD && !full_q) begin
        roll_tot_q  <= roll_tot_q + SUM_W'(roll_q);
        pitch_tot_q <= pitch_tot_q + SUM_W'(pitch_q);
        rsqt_q      <= rsqt_q + SQ_W'(rsq_q);
        psqt_q      <= psqt_q + SQ_W'(psq_q);
        tally_q     <= tally_q + CB'(1);
      end
      if (out_fire) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ax_q <= s_axis_tdata_i[15:0];
      ay_q <= s_axis_tdata_i[31:16];
      az_q <= s_axis_tdata_i[47:32];
    end
    if (state_q == ST_WROLL && chain_out.valid) roll_q <= roll_new;
    if (state_q == ST_WMAG && !isq_busy) mag_q <= isq_root;
    if (state_q == ST_WPIT && chain_out.valid) pitch_q <= 15'(pitch_new);
    if (state_q == ST_SQ) begin
      rsq_q  <= 30'(32'(roll_q) * 32'(roll_q));
      psq_q  <= 30'(32'(pitch_q) * 32'(pitch_q));
      full_q <= &tally_q;
    end
    if (state_q == ST_DWAIT && !div_busy) begin
      unique case (div_idx_q)
        DIV_MR:  m_r_q <= div_quo[30:0];
        DIV_MP:  m_p_q <= div_quo[30:0];
        DIV_ER:  e_r_q <= div_quo[61:0];
        default: e_p_q <= div_quo[61:0];
      endcase
    end
    if (state_q == ST_MSQ) begin
      mr2_q <= 62'(m_r_q) * 62'(m_r_q);
      mp2_q <= 62'(m_p_q) * 62'(m_p_q);
    end
    if (state_q == ST_VAR) begin
      v_r_q <= (e_r_q > mr2_q) ? e_r_q - mr2_q : '0;
      v_p_q <= (e_p_q > mp2_q) ? e_p_q - mp2_q : '0;
    end
    if (state_q == ST_SRW && !isq_busy) root_r_q <= isq_root;
    if (state_q == ST_SPW && !isq_busy) root_p_q <= isq_root;
    if (out_fire) begin
      out_data_q <= OUT_W'({pitch_spread, roll_spread, pitch_mean, roll_mean,
                            tally_q, pitch_q, roll_q});
      out_full_q <= full_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_full_q;

  a_tally_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tally_q != $past(tally_q)) |-> (tally_q == $past(tally_q) + CB'(1)))
    else $error("sample count changed by other than one");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == ST_OUT))
    else $error("result raised outside output state");

  a_isq_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    isq_start |-> !isq_busy)
    else $error("root unit restarted while busy");

  a_cordic_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_out.valid |-> (state_q == ST_WROLL || state_q == ST_WPIT))
    else $error("CORDIC result arrived outside a wait state");

endmodule
`default_nettype wire
